@@ rtl/tvo_pkg.sv @@
package tvo_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int SIZE_W = 23;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// Vertex that closes each triangle edge, and the axes of the xy, yz and zx projections.
	localparam int NEXT_VERT [3] = '{1, 2, 0};
	localparam int AXIS_A [3] = '{0, 1, 2};
	localparam int AXIS_B [3] = '{1, 2, 0};
	localparam int AXIS_T [3] = '{2, 0, 1};

	typedef struct packed {
		logic zx_pass;
		logic yz_pass;
		logic xy_pass;
		logic plane_hit;
		logic overlaps;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/triangle_voxel_overlap_test.sv @@
// An accepted input transaction passes through the registers of tvo_diff, tvo_prod,
// tvo_sum and tvo_verdict. Throughput is one transaction per cycle unless the output
// stalls; each register stage advances on its own, so bubbles close up while it waits.
// arst_n clears all stage valid bits at once and sets the three voxel sizes to 256.
// A size write reaches every transaction that enters the second stage after it.
module triangle_voxel_overlap_test #(
	parameter int COORD_WIDTH = tvo_pkg::COORD_WIDTH,
	localparam int IN_W = ((12 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((tvo_pkg::RESULT_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// box_low_x, box_low_y, box_low_z, vert0_x, vert0_y, vert0_z,
	// vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, then zero fill.
	input  logic [IN_W-1:0]               s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// overlaps, plane_hit, xy_pass, yz_pass, zx_pass, then zero fill.
	output logic [OUT_W-1:0]              m_tdata,
	input  logic                          cfg_we,
	input  logic [tvo_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [tvo_pkg::SIZE_W-1:0]    cfg_data
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * COORD_WIDTH + 2;
	localparam int NW = 2 * COORD_WIDTH + 3;
	localparam int SW = tvo_pkg::SIZE_W;
	localparam int EPW = (PW > SW + DW + 1) ? PW : SW + DW + 1;
	localparam int SUMW = EPW + 2;
	localparam int TW = ((DW > SW + 1) ? DW : SW + 1) + 1;

	logic [SW-1:0] size_q [3];

	logic signed [COORD_WIDTH-1:0] p [3];
	logic signed [COORD_WIDTH-1:0] v [3][3];

	logic en1, en2, en3, en4, en5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic signed [DW-1:0]   e_s1 [3][3];
	logic signed [DW-1:0]   q_s1 [3][3];
	logic signed [PW-1:0]   np_s2 [6];
	logic signed [EPW-1:0]  pa_s2 [3][3];
	logic signed [EPW-1:0]  pb_s2 [3][3];
	logic signed [EPW-1:0]  pc_s2 [3][3];
	logic signed [EPW-1:0]  pd_s2 [3][3];
	logic signed [DW-1:0]   e_s2 [3][3];
	logic signed [TW-1:0]   base_s2 [3];
	logic signed [TW-1:0]   bd_s2 [3];
	logic signed [NW-1:0]   n_s3 [3];
	logic signed [SUMW-1:0] vu_s3 [3][3];
	logic signed [SUMW-1:0] vf_s3 [3][3];
	logic signed [TW-1:0]   base_s3 [3];
	logic signed [TW-1:0]   bd_s3 [3];
	tvo_pkg::result_t       result_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0] <= tvo_pkg::SIZE_RESET;
			size_q[1] <= tvo_pkg::SIZE_RESET;
			size_q[2] <= tvo_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tvo_pkg::REG_SIZE_X: size_q[0] <= cfg_data;
				tvo_pkg::REG_SIZE_Y: size_q[1] <= cfg_data;
				tvo_pkg::REG_SIZE_Z: size_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p[k] = s_tdata[k * COORD_WIDTH +: COORD_WIDTH];
			for (int t = 0; t < 3; t++) begin
				v[t][k] = s_tdata[(3 + 3 * t + k) * COORD_WIDTH +: COORD_WIDTH];
			end
		end
	end

	assign en5 = !valid_s5 || m_tready;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_tready = en1;

	tvo_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.valid_in (s_tvalid),
		.p        (p),
		.v        (v),
		.valid_s1 (valid_s1),
		.e_s1     (e_s1),
		.q_s1     (q_s1)
	);

	tvo_prod #(.COORD_WIDTH(COORD_WIDTH)) u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.e_s1     (e_s1),
		.q_s1     (q_s1),
		.dp       (size_q),
		.valid_s2 (valid_s2),
		.np_s2    (np_s2),
		.pa_s2    (pa_s2),
		.pb_s2    (pb_s2),
		.pc_s2    (pc_s2),
		.pd_s2    (pd_s2),
		.e_s2     (e_s2),
		.base_s2  (base_s2),
		.bd_s2    (bd_s2)
	);

	tvo_sum #(.COORD_WIDTH(COORD_WIDTH)) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.np_s2    (np_s2),
		.pa_s2    (pa_s2),
		.pb_s2    (pb_s2),
		.pc_s2    (pc_s2),
		.pd_s2    (pd_s2),
		.e_s2     (e_s2),
		.base_s2  (base_s2),
		.bd_s2    (bd_s2),
		.valid_s3 (valid_s3),
		.n_s3     (n_s3),
		.vu_s3    (vu_s3),
		.vf_s3    (vf_s3),
		.base_s3  (base_s3),
		.bd_s3    (bd_s3)
	);

	tvo_verdict #(.COORD_WIDTH(COORD_WIDTH)) u_verdict (
		.clk       (clk),
		.arst_n    (arst_n),
		.en4       (en4),
		.en5       (en5),
		.valid_s3  (valid_s3),
		.n_s3      (n_s3),
		.vu_s3     (vu_s3),
		.vf_s3     (vf_s3),
		.base_s3   (base_s3),
		.bd_s3     (bd_s3),
		.valid_s4  (valid_s4),
		.valid_s5  (valid_s5),
		.result_s5 (result_s5)
	);

	assign m_tvalid = valid_s5;
	assign m_tdata  = {{(OUT_W - tvo_pkg::RESULT_W){1'b0}}, result_s5};

endmodule

@@ rtl/tvo_diff.sv @@
module tvo_diff #(
	parameter int COORD_WIDTH = tvo_pkg::COORD_WIDTH,
	localparam int DW = COORD_WIDTH + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  logic signed [COORD_WIDTH-1:0] p [3],
	input  logic signed [COORD_WIDTH-1:0] v [3][3],
	output logic                          valid_s1,
	output logic signed [DW-1:0]          e_s1 [3][3],
	output logic signed [DW-1:0]          q_s1 [3][3]
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// Edge i runs from vertex i to the next one; q holds the box corner relative to vertex i.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					e_s1[i][k] <= DW'(v[tvo_pkg::NEXT_VERT[i]][k]) - DW'(v[i][k]);
					q_s1[i][k] <= DW'(p[k]) - DW'(v[i][k]);
				end
			end
		end
	end

endmodule

@@ rtl/tvo_prod.sv @@
module tvo_prod #(
	parameter int COORD_WIDTH = tvo_pkg::COORD_WIDTH,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * COORD_WIDTH + 2,
	localparam int SW = tvo_pkg::SIZE_W,
	localparam int EPW = (PW > SW + DW + 1) ? PW : SW + DW + 1,
	localparam int TW = ((DW > SW + 1) ? DW : SW + 1) + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_s1,
	input  logic signed [DW-1:0] e_s1 [3][3],
	input  logic signed [DW-1:0] q_s1 [3][3],
	input  logic [SW-1:0]        dp [3],
	output logic                 valid_s2,
	output logic signed [PW-1:0] np_s2 [6],
	output logic signed [EPW-1:0] pa_s2 [3][3],
	output logic signed [EPW-1:0] pb_s2 [3][3],
	output logic signed [EPW-1:0] pc_s2 [3][3],
	output logic signed [EPW-1:0] pd_s2 [3][3],
	output logic signed [DW-1:0] e_s2 [3][3],
	output logic signed [TW-1:0] base_s2 [3],
	output logic signed [TW-1:0] bd_s2 [3]
);

	logic signed [PW-1:0]  np_d [6];
	logic signed [EPW-1:0] pa_d [3][3];
	logic signed [EPW-1:0] pb_d [3][3];
	logic signed [EPW-1:0] pc_d [3][3];
	logic signed [EPW-1:0] pd_d [3][3];

	// The normal is -(e0 x e2); each component is the difference of a product pair.
	always_comb begin
		np_d[0] = PW'(e_s1[0][2]) * PW'(e_s1[2][1]);
		np_d[1] = PW'(e_s1[0][1]) * PW'(e_s1[2][2]);
		np_d[2] = PW'(e_s1[0][0]) * PW'(e_s1[2][2]);
		np_d[3] = PW'(e_s1[0][2]) * PW'(e_s1[2][0]);
		np_d[4] = PW'(e_s1[0][1]) * PW'(e_s1[2][0]);
		np_d[5] = PW'(e_s1[0][0]) * PW'(e_s1[2][1]);
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 3; i++) begin
				pa_d[r][i] = EPW'(e_s1[i][tvo_pkg::AXIS_B[r]]) *
					EPW'(q_s1[i][tvo_pkg::AXIS_A[r]]);
				pb_d[r][i] = EPW'(e_s1[i][tvo_pkg::AXIS_A[r]]) *
					EPW'(q_s1[i][tvo_pkg::AXIS_B[r]]);
				pc_d[r][i] = EPW'($signed({1'b0, dp[tvo_pkg::AXIS_A[r]]})) *
					EPW'(e_s1[i][tvo_pkg::AXIS_B[r]]);
				pd_d[r][i] = EPW'($signed({1'b0, dp[tvo_pkg::AXIS_B[r]]})) *
					EPW'(e_s1[i][tvo_pkg::AXIS_A[r]]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s2 <= np_d;
			pa_s2 <= pa_d;
			pb_s2 <= pb_d;
			pc_s2 <= pc_d;
			pd_s2 <= pd_d;
			e_s2  <= e_s1;
			for (int k = 0; k < 3; k++) begin
				base_s2[k] <= TW'(q_s1[0][k]);
				bd_s2[k]   <= TW'(q_s1[0][k]) + TW'($signed({1'b0, dp[k]}));
			end
		end
	end

endmodule

@@ rtl/tvo_sum.sv @@
module tvo_sum #(
	parameter int COORD_WIDTH = tvo_pkg::COORD_WIDTH,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * COORD_WIDTH + 2,
	localparam int NW = 2 * COORD_WIDTH + 3,
	localparam int SW = tvo_pkg::SIZE_W,
	localparam int EPW = (PW > SW + DW + 1) ? PW : SW + DW + 1,
	localparam int SUMW = EPW + 2,
	localparam int TW = ((DW > SW + 1) ? DW : SW + 1) + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_s2,
	input  logic signed [PW-1:0]   np_s2 [6],
	input  logic signed [EPW-1:0]  pa_s2 [3][3],
	input  logic signed [EPW-1:0]  pb_s2 [3][3],
	input  logic signed [EPW-1:0]  pc_s2 [3][3],
	input  logic signed [EPW-1:0]  pd_s2 [3][3],
	input  logic signed [DW-1:0]   e_s2 [3][3],
	input  logic signed [TW-1:0]   base_s2 [3],
	input  logic signed [TW-1:0]   bd_s2 [3],
	output logic                   valid_s3,
	output logic signed [NW-1:0]   n_s3 [3],
	output logic signed [SUMW-1:0] vu_s3 [3][3],
	output logic signed [SUMW-1:0] vf_s3 [3][3],
	output logic signed [TW-1:0]   base_s3 [3],
	output logic signed [TW-1:0]   bd_s3 [3]
);

	logic signed [SUMW-1:0] vu_d [3][3];
	logic signed [SUMW-1:0] vf_d [3][3];
	logic                   a_neg, a_pos, b_neg, b_pos;
	logic signed [SUMW-1:0] ta, tb, tc, td;

	// vu is the edge value with the projected edge normal as is, vf with it negated.
	always_comb begin
		a_neg = 1'b0;
		a_pos = 1'b0;
		b_neg = 1'b0;
		b_pos = 1'b0;
		ta = '0;
		tb = '0;
		tc = '0;
		td = '0;
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 3; i++) begin
				a_neg = e_s2[i][tvo_pkg::AXIS_A[r]][DW-1];
				a_pos = !a_neg && (|e_s2[i][tvo_pkg::AXIS_A[r]]);
				b_neg = e_s2[i][tvo_pkg::AXIS_B[r]][DW-1];
				b_pos = !b_neg && (|e_s2[i][tvo_pkg::AXIS_B[r]]);
				ta = SUMW'(pa_s2[r][i]);
				tb = SUMW'(pb_s2[r][i]);
				tc = SUMW'(pc_s2[r][i]);
				td = SUMW'(pd_s2[r][i]);
				vu_d[r][i] = tb - ta + (b_neg ? -tc : '0) + (a_pos ? td : '0);
				vf_d[r][i] = ta - tb + (b_pos ? tc : '0) + (a_neg ? -td : '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				n_s3[k] <= NW'(np_s2[2 * k]) - NW'(np_s2[2 * k + 1]);
			end
			vu_s3   <= vu_d;
			vf_s3   <= vf_d;
			base_s3 <= base_s2;
			bd_s3   <= bd_s2;
		end
	end

endmodule

@@ rtl/tvo_verdict.sv @@
module tvo_verdict #(
	parameter int COORD_WIDTH = tvo_pkg::COORD_WIDTH,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * COORD_WIDTH + 2,
	localparam int NW = 2 * COORD_WIDTH + 3,
	localparam int SW = tvo_pkg::SIZE_W,
	localparam int EPW = (PW > SW + DW + 1) ? PW : SW + DW + 1,
	localparam int SUMW = EPW + 2,
	localparam int TW = ((DW > SW + 1) ? DW : SW + 1) + 1,
	localparam int L = NW / 2,
	localparam int LOW = L + 1 + TW,
	localparam int HIW = NW - L + TW,
	localparam int SAW = NW + TW + 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en4,
	input  logic                   en5,
	input  logic                   valid_s3,
	input  logic signed [NW-1:0]   n_s3 [3],
	input  logic signed [SUMW-1:0] vu_s3 [3][3],
	input  logic signed [SUMW-1:0] vf_s3 [3][3],
	input  logic signed [TW-1:0]   base_s3 [3],
	input  logic signed [TW-1:0]   bd_s3 [3],
	output logic                   valid_s4,
	output logic                   valid_s5,
	output tvo_pkg::result_t       result_s5
);

	logic signed [LOW-1:0] lo_a_d [3];
	logic signed [LOW-1:0] lo_b_d [3];
	logic signed [HIW-1:0] hi_a_d [3];
	logic signed [HIW-1:0] hi_b_d [3];
	logic [2:0]            pass_d;
	logic                  n_pos, flip;
	logic [2:0]            edge_ok;
	logic signed [TW-1:0]  ta, tb;

	logic signed [LOW-1:0] lo_a_s4 [3];
	logic signed [LOW-1:0] lo_b_s4 [3];
	logic signed [HIW-1:0] hi_a_s4 [3];
	logic signed [HIW-1:0] hi_b_s4 [3];
	logic [2:0]            pass_s4;

	logic signed [SAW-1:0] sa, sb;
	logic                  plane;

	// The wide normal is split into a low unsigned half and a high signed half per product.
	always_comb begin
		n_pos = 1'b0;
		ta = '0;
		tb = '0;
		for (int k = 0; k < 3; k++) begin
			n_pos = !n_s3[k][NW-1] && (|n_s3[k]);
			ta = n_pos ? bd_s3[k] : base_s3[k];
			tb = n_pos ? base_s3[k] : bd_s3[k];
			lo_a_d[k] = LOW'($signed({1'b0, n_s3[k][L-1:0]})) * LOW'(ta);
			lo_b_d[k] = LOW'($signed({1'b0, n_s3[k][L-1:0]})) * LOW'(tb);
			hi_a_d[k] = HIW'($signed(n_s3[k][NW-1:L])) * HIW'(ta);
			hi_b_d[k] = HIW'($signed(n_s3[k][NW-1:L])) * HIW'(tb);
		end
	end

	always_comb begin
		flip = 1'b0;
		edge_ok = '0;
		for (int r = 0; r < 3; r++) begin
			flip = n_s3[tvo_pkg::AXIS_T[r]][NW-1];
			for (int i = 0; i < 3; i++) begin
				edge_ok[i] = flip ? !vf_s3[r][i][SUMW-1] : !vu_s3[r][i][SUMW-1];
			end
			pass_d[r] = &edge_ok;
		end
	end

	always_comb begin
		sa = '0;
		sb = '0;
		for (int k = 0; k < 3; k++) begin
			sa = sa + (SAW'(hi_a_s4[k]) <<< L) + SAW'(lo_a_s4[k]);
			sb = sb + (SAW'(hi_b_s4[k]) <<< L) + SAW'(lo_b_s4[k]);
		end
		plane = (sa == '0) || (sb == '0) || (sa[SAW-1] != sb[SAW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en4) begin
				valid_s4 <= valid_s3;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			lo_a_s4 <= lo_a_d;
			lo_b_s4 <= lo_b_d;
			hi_a_s4 <= hi_a_d;
			hi_b_s4 <= hi_b_d;
			pass_s4 <= pass_d;
		end
		if (en5) begin
			result_s5.overlaps  <= plane && (&pass_s4);
			result_s5.plane_hit <= plane;
			result_s5.xy_pass   <= pass_s4[0];
			result_s5.yz_pass   <= pass_s4[1];
			result_s5.zx_pass   <= pass_s4[2];
		end
	end

endmodule

@@ verif/triangle_voxel_overlap_test_tb.sv @@
module triangle_voxel_overlap_test_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = tvo_pkg::COORD_WIDTH;
	localparam int SW = tvo_pkg::SIZE_W;
	localparam int IDXW = tvo_pkg::REG_IDX_W;
	localparam int RW = tvo_pkg::RESULT_W;
	localparam int IN_W = ((12 * CW + 7) / 8) * 8;
	localparam int OUT_W = ((RW + 7) / 8) * 8;
	localparam int MAXC = 8388607;
	localparam int MINC = -8388608;
	localparam logic [SW-1:0] SIZE_MAX = SW'(8388607);
	localparam logic [IDXW-1:0] REG_UNUSED = 2'd3;
	localparam int LATENCY = 5;
	localparam int PAIRS_PER_PHASE = 185;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam tvo_pkg::result_t ALL_PASS = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

	// Twelve coordinates, box_low_x in the lowest bits up to vert2_z.
	typedef logic [11:0][CW-1:0] pair_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		pair_t pair;
		bit known;
		tvo_pkg::result_t verdict;
	} pair_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we;
	logic [IDXW-1:0] cfg_index;
	logic [SW-1:0] cfg_data;

	logic [SW-1:0] voxel_size [3];
	tvo_pkg::result_t pending_verdicts [$];
	int fail_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit want_hold = 1'b0;

	triangle_voxel_overlap_test DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic tvo_pkg::result_t predict_verdict(pair_t d);
		wide_t p [3];
		wide_t dp [3];
		wide_t v [3][3];
		wide_t e0 [3];
		wide_t f [3];
		wide_t n [3];
		wide_t sa, sb, corner, rel, na, nb, acc;
		bit plane, flip;
		bit [2:0] proj_ok;
		int k, t, i, j, pr, a, b, c;
		tvo_pkg::result_t r;
		for (k = 0; k < 3; k++) begin
			p[k] = $signed(d[k]);
			dp[k] = voxel_size[k];
		end
		for (t = 0; t < 3; t++)
			for (k = 0; k < 3; k++)
				v[t][k] = $signed(d[3 + 3 * t + k]);
		for (k = 0; k < 3; k++) begin
			e0[k] = v[1][k] - v[0][k];
			f[k] = v[2][k] - v[0][k];
		end
		n[0] = e0[1] * f[2] - e0[2] * f[1];
		n[1] = e0[2] * f[0] - e0[0] * f[2];
		n[2] = e0[0] * f[1] - e0[1] * f[0];
		sa = 0;
		sb = 0;
		for (k = 0; k < 3; k++) begin
			corner = (n[k] > 0) ? dp[k] : 0;
			rel = p[k] - v[0][k];
			sa = sa + n[k] * (rel + corner);
			sb = sb + n[k] * (rel + dp[k] - corner);
		end
		plane = !((sa > 0 && sb > 0) || (sa < 0 && sb < 0));
		for (pr = 0; pr < 3; pr++) begin
			a = pr;
			b = (pr + 1) % 3;
			c = (pr + 2) % 3;
			flip = n[c] < 0;
			proj_ok[pr] = 1'b1;
			for (i = 0; i < 3; i++) begin
				j = (i + 1) % 3;
				na = v[i][b] - v[j][b];
				nb = v[j][a] - v[i][a];
				if (flip) begin
					na = -na;
					nb = -nb;
				end
				acc = na * (p[a] - v[i][a]) + nb * (p[b] - v[i][b]);
				if (na > 0)
					acc = acc + dp[a] * na;
				if (nb > 0)
					acc = acc + dp[b] * nb;
				if (acc < 0)
					proj_ok[pr] = 1'b0;
			end
		end
		r.plane_hit = plane;
		r.xy_pass = proj_ok[0];
		r.yz_pass = proj_ok[1];
		r.zx_pass = proj_ok[2];
		r.overlaps = plane & (&proj_ok);
		return r;
	endfunction

	function automatic pair_t make_pair(int px, int py, int pz, int x0, int y0, int z0,
			int x1, int y1, int z1, int x2, int y2, int z2);
		pair_t d;
		d[0] = px[CW-1:0];
		d[1] = py[CW-1:0];
		d[2] = pz[CW-1:0];
		d[3] = x0[CW-1:0];
		d[4] = y0[CW-1:0];
		d[5] = z0[CW-1:0];
		d[6] = x1[CW-1:0];
		d[7] = y1[CW-1:0];
		d[8] = z1[CW-1:0];
		d[9] = x2[CW-1:0];
		d[10] = y2[CW-1:0];
		d[11] = z2[CW-1:0];
		return d;
	endfunction

	// Mostly triangles near the voxel, some on its faces, some degenerate, some anywhere.
	function automatic pair_t random_pair();
		pair_t d;
		int kind, shape, k, t, sz, base, value;
		kind = $urandom_range(0, 99);
		for (k = 0; k < 12; k++)
			d[k] = CW'($urandom);
		if (kind >= 15) begin
			for (k = 0; k < 3; k++)
				if ($urandom_range(0, 3) != 0)
					d[k] = CW'(int'($urandom_range(0, 4095)) - 2048);
			for (t = 0; t < 3; t++)
				for (k = 0; k < 3; k++) begin
					sz = int'(voxel_size[k]);
					base = int'($signed(d[k]));
					if (kind < 35) begin
						case ($urandom_range(0, 3))
							0: value = base;
							1: value = base + sz;
							2: value = base + int'($urandom_range(0, sz));
							default: value = base + int'($urandom_range(0, 2)) - 1;
						endcase
					end else begin
						value = base + int'($urandom_range(0, 4 * sz + 2)) - 2 * sz;
					end
					d[3 + 3 * t + k] = value[CW-1:0];
				end
			if (kind >= 35 && kind < 45) begin
				shape = $urandom_range(0, 2);
				for (k = 0; k < 3; k++)
					case (shape)
						0: d[6 + k] = d[3 + k];
						1: d[9 + k] = d[6 + k];
						default: d[9 + k] = CW'(2 * int'($signed(d[6 + k]))
							- int'($signed(d[3 + k])));
					endcase
			end
		end
		return d;
	endfunction

	task automatic send_pair(input pair_t d, input bit known,
			input tvo_pkg::result_t verdict);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_verdicts.insert(pending_verdicts.size(),
			known ? verdict : predict_verdict(d));
		@(negedge clk);
	endtask

	task automatic write_size(input logic [IDXW-1:0] index, input logic [SW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		case (index)
			tvo_pkg::REG_SIZE_X: voxel_size[0] = value;
			tvo_pkg::REG_SIZE_Y: voxel_size[1] = value;
			tvo_pkg::REG_SIZE_Z: voxel_size[2] = value;
			default: ;
		endcase
	endtask

	task automatic drain_results();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 3) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		tvo_pkg::result_t got;
		tvo_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RW-1:0];
			if (pending_verdicts.size() == 0) begin
				$error("result transaction with nothing pending: %b", got);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("overlaps", want.overlaps, got.overlaps);
				check_field("plane_hit", want.plane_hit, got.plane_hit);
				check_field("xy_pass", want.xy_pass, got.xy_pass);
				check_field("yz_pass", want.yz_pass, got.yz_pass);
				check_field("zx_pass", want.zx_pass, got.zx_pass);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("triangle_voxel_overlap_test_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (want_hold && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	initial begin
		pair_row_t directed_rows [$];
		logic [SW-1:0] sizes [3];
		int phase, k, n_item;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (k = 0; k < 3; k++)
			voxel_size[k] = tvo_pkg::SIZE_RESET;

		directed_rows = '{
			'{make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ALL_PASS},
			'{make_pair(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
				MAXC, MAXC, MAXC), 1'b1, ALL_PASS},
			'{make_pair(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC,
				MINC, MINC, MINC), 1'b1, ALL_PASS},
			'{make_pair(0, 0, 0, -512, -512, 128, 1024, -512, 128, -512, 1024, 128),
				1'b0, '0},
			'{make_pair(0, 0, 0, -512, -512, 128, -512, 1024, 128, 1024, -512, 128),
				1'b0, '0},
			'{make_pair(0, 0, 0, -512, -512, 256, 1024, -512, 256, -512, 1024, 256),
				1'b0, '0},
			'{make_pair(0, 0, 0, -512, -512, 257, 1024, -512, 257, -512, 1024, 257),
				1'b0, '0},
			'{make_pair(0, 0, 0, 256, 256, 256, 1024, 256, 512, 256, 1024, 512),
				1'b0, '0},
			'{make_pair(0, 0, 0, 5000, -300, 20, -200, 6000, 40, 100, 50, 7000),
				1'b0, '0},
			'{make_pair(0, 0, 0, 300, -1000, -1000, 300, 1000, -1000, 2000, 0, 1000),
				1'b0, '0},
			'{make_pair(MINC, MINC, MINC, MINC, MINC, MINC, MAXC, MINC, MAXC,
				MINC, MAXC, MAXC), 1'b0, '0},
			'{make_pair(MAXC, MAXC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC,
				MAXC, MAXC, MINC), 1'b0, '0},
			'{make_pair(MAXC, MINC, 0, MINC, MAXC, MAXC, MAXC, MAXC, MINC,
				0, MINC, MAXC), 1'b0, '0},
			'{make_pair(0, 0, 0, -100, -100, -100, 128, 128, 128, 400, 400, 400),
				1'b0, '0},
			'{make_pair(0, 0, 0, 1000, 0, 0, 2000, 0, 0, 3000, 0, 0), 1'b0, '0},
			'{make_pair(0, 0, 0, 100, 100, 100, 100, 100, 100, 600, -200, 50),
				1'b0, '0},
			'{make_pair(-2048, -2048, -2048, -1900, -2000, -1800, -2100, -1700, -2000,
				-1800, -1900, -2100), 1'b0, '0}
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			send_pair(directed_rows[r].pair, directed_rows[r].known, directed_rows[r].verdict);
		s_tvalid <= 1'b0;
		drain_results();

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: sizes = '{tvo_pkg::SIZE_RESET, tvo_pkg::SIZE_RESET, tvo_pkg::SIZE_RESET};
				1: sizes = '{SW'(1), SW'(1), SW'(1)};
				2: sizes = '{SIZE_MAX, SIZE_MAX, SIZE_MAX};
				3: sizes = '{SW'(0), SW'(0), SW'(0)};
				4: sizes = '{SW'($urandom_range(1, 4096)), SW'($urandom_range(1, 4096)),
					SW'($urandom_range(1, 4096))};
				5: sizes = '{SW'(1), SIZE_MAX, SW'(300)};
				6: sizes = '{SW'($urandom), SW'($urandom), SW'($urandom)};
				default: sizes = '{SW'(256), SW'(512), SW'(128)};
			endcase
			if (phase == 7)
				write_size(REG_UNUSED, SW'($urandom));
			write_size(tvo_pkg::REG_SIZE_X, sizes[0]);
			write_size(tvo_pkg::REG_SIZE_Y, sizes[1]);
			write_size(tvo_pkg::REG_SIZE_Z, sizes[2]);
			cfg_we <= 1'b0;
			sender_idle_pct = (phase % 4 == 1) ? 82 : (phase % 4 == 3) ? 23 : 0;
			receiver_stall_pct = (phase % 4 == 2) ? 82 : (phase % 4 == 3) ? 23 : 0;
			if (phase == 0)
				want_hold = 1'b1;
			for (n_item = 0; n_item < PAIRS_PER_PHASE; n_item++)
				send_pair(random_pair(), 1'b0, '0);
			s_tvalid <= 1'b0;
			drain_results();
		end

		if (fail_count == 0 && pending_verdicts.size() == 0)
			$display("triangle_voxel_overlap_test_tb OK");
		else
			$display("triangle_voxel_overlap_test_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/tvo_pkg.sv
rtl/tvo_diff.sv
rtl/tvo_prod.sv
rtl/tvo_sum.sv
rtl/tvo_verdict.sv
rtl/triangle_voxel_overlap_test.sv
verif/triangle_voxel_overlap_test_tb.sv
